[design/blr_pkg.sv]
// Package for the beat repeat looper: field widths, saturation helpers,
// register indexes and the front-to-back queue entry type.
// No dependencies.
package blr_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned TICK_W     = 4;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned SIX_W      = LEN_W - 4;
  localparam int unsigned PROD_W     = SIX_W + CNT_W;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 17;

  // Loop length floor and register reset values
  localparam int unsigned LEN_MIN       = 16;
  localparam int unsigned LEN_RESET     = 65536;
  localparam int unsigned COUNT_RESET   = 1;
  localparam int unsigned SEL_RESET     = 0;

  // Quotient bits of the two modulo steps: position by loop length
  // (position below 2^16, length at least 16), relative position by
  // sixteenth length (quotient below 32, rounded up to an even count)
  localparam int unsigned POS_QUOT_W = POS_W - 4;
  localparam int unsigned REL_QUOT_W = 6;

  // Entries of the front-to-back queue
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOOP_LENGTH = 4'd0,
    REG_REPEAT_COUNT = 4'd1,
    REG_SELECTED = 4'd2,
    REG_ENABLE = 4'd3
  } blr_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One classified sample on its way to the back end
  typedef struct packed {
    sample_t            left;
    sample_t            right;
    logic               wr;     // record left into the loop store
    logic               play;   // inside the repeat window
    logic [POS_W-1:0]   rel;    // position reduced by the loop length
    logic [SIX_W-1:0]   six;    // sixteenth length in frames
  } blr_entry_t;

  localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Add two samples and clamp to the sample range
  function automatic sample_t sat_add(input sample_t a, input sample_t b);
    logic signed [SAMPLE_W:0] s;
    s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      return s[SAMPLE_W] ? SAT_MIN : SAT_MAX;
    end
    return s[SAMPLE_W-1:0];
  endfunction

endpackage

[design/blr_in_if.sv]
// Input sample channel of the beat repeat looper.
// Depends on blr_pkg.
interface blr_in_if import blr_pkg::*; ();
  logic              valid;
  logic              ready;
  sample_t           sample_left;
  sample_t           sample_right;
  logic [POS_W-1:0]  loop_position;
  logic [TICK_W-1:0] sixteenth_tick;

  modport source (output valid, sample_left, sample_right, loop_position,
                  sixteenth_tick, input ready);
  modport sink (input valid, sample_left, sample_right, loop_position,
                sixteenth_tick, output ready);
endinterface

[design/blr_out_if.sv]
// Output sample channel of the beat repeat looper.
// Depends on blr_pkg.
interface blr_out_if import blr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink (input valid, out_left, out_right, output ready);
endinterface

[design/blr_cfg_if.sv]
// Register write channel of the beat repeat looper.
// Depends on blr_pkg.
interface blr_cfg_if import blr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/blr_divmod.sv]
// Iterative remainder unit, two restoring steps per cycle.
// Requires dividend below divisor shifted left by QW. Depends on nothing.
module blr_divmod #(
  parameter int unsigned DW = 16,
  parameter int unsigned VW = 17,
  parameter int unsigned QW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = (DW > VW) ? DW : VW;
  localparam int unsigned SW = $clog2(QW + 1);

  logic [SW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q;
  logic [DW-1:0] r1;

  // Subtract the divisor shifted by sh when it fits
  function automatic logic [DW-1:0] sub_step(input logic [DW-1:0] r,
                                             input logic [VW-1:0] d,
                                             input logic [SW-1:0] sh);
    logic [CW-1:0] hi;
    logic [CW-1:0] dx;
    logic [DW-1:0] ds;
    hi = CW'(r >> sh);
    dx = CW'(d);
    ds = DW'(d) << sh;
    if (hi >= dx) begin
      return r - ds;
    end
    return r;
  endfunction

  // Two quotient bits per cycle, high bits first
  always_comb begin
    r1    = rem_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cnt_q >= SW'(1)) begin
      r1 = sub_step(rem_q, dvs_q, cnt_q - SW'(1));
    end
    if (cnt_q >= SW'(2)) begin
      rem_d = sub_step(r1, dvs_q, cnt_q - SW'(2));
      cnt_d = cnt_q - SW'(2);
    end else begin
      rem_d = r1;
      cnt_d = '0;
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= SW'(QW);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dvs_q <= divisor_i;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

endmodule

[design/blr_front.sv]
// Front end: configuration registers, sample intake, recording control and
// repeat window classification. Depends on blr_pkg, blr_divmod, interfaces.
module blr_front import blr_pkg::*; #(
  parameter int unsigned LOOP_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  blr_in_if.sink      in_i,
  blr_cfg_if.sink     cfg_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output blr_entry_t  entry_o
);

  localparam int unsigned AW     = $clog2(LOOP_DEPTH);
  localparam int unsigned NW     = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam int unsigned LenMax = (1 << LEN_W) - 1;
  localparam int unsigned LenCap = (LOOP_DEPTH < LenMax) ? LOOP_DEPTH : LenMax;

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_MUL   = 7'b0000010,
    F_START = 7'b0000100,
    F_SUM   = 7'b0001000,
    F_END1  = 7'b0010000,
    F_END2  = 7'b0100000,
    F_WAIT  = 7'b1000000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [LEN_W-1:0] loop_length_q;
  logic [CNT_W-1:0] repeat_count_q;
  logic [SEL_W-1:0] selected_q;
  logic             enable_q;

  logic             recording_q, captured_q;
  logic [AW-1:0]    wpos_q;

  sample_t           left_q, right_q;
  logic [POS_W-1:0]  pos_q;
  logic [TICK_W-1:0] tick_q;
  logic [LEN_W-1:0]  len_q;
  logic [PROD_W-1:0] start_raw_q, span_q;
  logic [LEN_W-1:0]  start_q;
  logic [SUM_W-1:0]  end_q;

  logic [SIX_W-1:0]  six;
  logic [CNT_W-1:0]  sel_p1;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  end_v;
  logic              div_start, div_busy;
  logic [POS_W-1:0]  rel;
  logic              in_window, rec_now, rec_done, push;
  logic [AW:0]       wpos_next;

  assign cfg_i.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_length_q  <= LEN_W'(LEN_RESET);
      repeat_count_q <= CNT_W'(COUNT_RESET);
      selected_q     <= SEL_W'(SEL_RESET);
      enable_q       <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LOOP_LENGTH:  loop_length_q  <= LEN_W'(cfg_i.data);
        REG_REPEAT_COUNT: repeat_count_q <= CNT_W'(cfg_i.data);
        REG_SELECTED:     selected_q     <= SEL_W'(cfg_i.data);
        REG_ENABLE:       enable_q       <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Clamp the loop length to the floor and to the store
  always_comb begin
    if (loop_length_q < LEN_W'(LEN_MIN)) begin
      len_eff = LEN_W'(LEN_MIN);
    end else if (loop_length_q > LEN_W'(LenCap)) begin
      len_eff = LEN_W'(LenCap);
    end else begin
      len_eff = loop_length_q;
    end
  end

  assign six    = len_q[LEN_W-1:4];
  assign sel_p1 = CNT_W'(selected_q) + CNT_W'(1);
  assign end_v  = LEN_W'(end_q);

  // Position modulo loop length
  blr_divmod #(
    .DW(POS_W),
    .VW(LEN_W),
    .QW(POS_QUOT_W)
  ) u_pos_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pos_q),
    .divisor_i  (len_q),
    .busy_o     (div_busy),
    .rem_o      (rel)
  );

  assign div_start = (state_q == F_MUL);
  assign in_i.ready = (state_q == F_IDLE);

  // Window membership with strict bounds, wrapping past the loop end
  always_comb begin
    if (end_v < start_q) begin
      in_window = ((rel > POS_W'(0)) && (LEN_W'(rel) < end_v)) ||
                  ((LEN_W'(rel) > start_q) && (LEN_W'(rel) < len_q));
    end else begin
      in_window = (LEN_W'(rel) > start_q) && (LEN_W'(rel) < end_v);
    end
  end

  // Recording decision for the current sample
  assign rec_now   = recording_q || ((tick_q == '0) && !captured_q);
  assign wpos_next = (AW + 1)'(wpos_q) + (AW + 1)'(1);
  assign rec_done  = NW'(wpos_next) >= NW'(len_q);

  assign push         = (state_q == F_WAIT) && !div_busy && push_ready_i;
  assign push_valid_o = (state_q == F_WAIT) && !div_busy;

  always_comb begin
    entry_o.left  = left_q;
    entry_o.right = right_q;
    entry_o.wr    = rec_now;
    entry_o.play  = (captured_q || (rec_now && rec_done)) && enable_q && in_window;
    entry_o.rel   = rel;
    entry_o.six   = six;
  end

  // Sequence one sample through the window arithmetic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_i.valid) state_d = F_MUL;
      F_MUL:   state_d = F_START;
      F_START: state_d = F_SUM;
      F_SUM:   state_d = F_END1;
      F_END1:  state_d = F_END2;
      F_END2:  state_d = F_WAIT;
      F_WAIT:  if (push) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      recording_q <= 1'b0;
      captured_q  <= 1'b0;
      wpos_q      <= '0;
    end else begin
      state_q <= state_d;
      // Advance the recording on hand-off
      if (push && rec_now) begin
        if (rec_done) begin
          captured_q  <= 1'b1;
          recording_q <= 1'b0;
          wpos_q      <= '0;
        end else begin
          recording_q <= 1'b1;
          wpos_q      <= AW'(wpos_next);
        end
      end
    end
  end

  // Sample and window datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (in_i.valid) begin
          left_q  <= in_i.sample_left;
          right_q <= in_i.sample_right;
          pos_q   <= in_i.loop_position;
          tick_q  <= in_i.sixteenth_tick;
          len_q   <= len_eff;
        end
      end
      F_MUL: begin
        start_raw_q <= PROD_W'(sel_p1) * PROD_W'(six);
        span_q      <= PROD_W'(repeat_count_q) * PROD_W'(six);
      end
      F_START: begin
        if (start_raw_q >= PROD_W'(len_q)) begin
          start_q <= LEN_W'(start_raw_q - PROD_W'(len_q));
        end else begin
          start_q <= LEN_W'(start_raw_q);
        end
      end
      F_SUM:   end_q <= SUM_W'(start_q) + SUM_W'(span_q);
      F_END1, F_END2: begin
        if (end_q >= SUM_W'(len_q)) begin
          end_q <= end_q - SUM_W'(len_q);
        end
      end
      F_WAIT: ;
      default: ;
    endcase
  end

endmodule

[design/blr_queue.sv]
// Short queue of classified samples between front and back end.
// Depends on blr_pkg.
module blr_queue import blr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  blr_entry_t push_entry_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output blr_entry_t pop_entry_o
);

  localparam int unsigned PW = $clog2(Q_DEPTH);

  blr_entry_t        slot_q [Q_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PW:0]       fill_q;
  logic              push, pop;

  assign push_ready_o = (fill_q != (PW + 1)'(Q_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = slot_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (push && !pop) begin
        fill_q <= fill_q + (PW + 1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (PW + 1)'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

[design/blr_back.sv]
// Back end: loop store, slice offset modulo, saturating mix and the
// output register. Depends on blr_pkg, blr_divmod, blr_out_if.
module blr_back import blr_pkg::*; #(
  parameter int unsigned LOOP_DEPTH = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  blr_entry_t pop_entry_i,
  blr_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(LOOP_DEPTH);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SUM  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  sample_t         mem_q [LOOP_DEPTH];
  sample_t         rdata_q;
  logic [AW-1:0]   wptr_q;
  blr_entry_t      ent_q;
  sample_t         res_l_q, res_r_q;
  logic            out_valid_q;
  sample_t         out_l_q, out_r_q;

  logic            pop, div_start, div_busy, mem_re, out_load;
  logic [POS_W-1:0] slice_idx;
  sample_t         mix;

  assign pop_ready_o = (state_q == B_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign div_start   = pop && pop_entry_i.play;
  assign mem_re      = (state_q == B_DIV) && !div_busy;
  assign out_load    = (state_q == B_OUT) && (!out_valid_q || out_o.ready);
  assign mix         = sat_add(ent_q.left, rdata_q);

  // Offset into the recorded slice
  blr_divmod #(
    .DW(POS_W),
    .VW(SIX_W),
    .QW(REL_QUOT_W)
  ) u_slice_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pop_entry_i.rel),
    .divisor_i  (pop_entry_i.six),
    .busy_o     (div_busy),
    .rem_o      (slice_idx)
  );

  // Loop store: record writes in order, registered read
  always_ff @(posedge clk_i) begin
    if (pop && pop_entry_i.wr) mem_q[wptr_q] <= pop_entry_i.left;
    if (mem_re) rdata_q <= mem_q[AW'(slice_idx)];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop) state_d = pop_entry_i.play ? B_DIV : B_OUT;
      end
      B_DIV:   if (!div_busy) state_d = B_SUM;
      B_SUM:   state_d = B_OUT;
      B_OUT:   if (out_load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Control: state, write pointer, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      wptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop && pop_entry_i.wr) wptr_q <= wptr_q + AW'(1);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: latch entry, form result, load output
  always_ff @(posedge clk_i) begin
    if (pop) begin
      ent_q   <= pop_entry_i;
      res_l_q <= pop_entry_i.left;
      res_r_q <= pop_entry_i.right;
    end
    if (state_q == B_SUM) begin
      res_l_q <= mix;
      res_r_q <= mix;
    end
    if (out_load) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_l_q;
  assign out_o.out_right = out_r_q;

endmodule

[design/beat_repeat_looper_unit.sv]
// Top level of the beat repeat looper: front end, queue and back end.
// Depends on blr_pkg, blr_front, blr_queue, blr_back and the interfaces.
//
//   Channel  Dir  Carries                                            Handshake
//   in_i     in   sample_left, sample_right, loop_position, tick     valid/ready
//   out_o    out  out_left, out_right                                valid/ready
//   cfg_i    in   index, data (loop_length, repeat_count,            valid/ready
//                 selected_sixteenth, enable)
//
// A sample passes the front end (window arithmetic and a position-modulo
// divider), then the back end (slice-offset divider, store read, mix,
// output load); the front end takes no new sample until it has pushed the
// last one, and it sets the sustained rate while the output is taken.
// rst_ni clears the control state asynchronously; the loop store holds no
// valid data until recorded. A stalled output fills the queue and then
// holds off in_i.
module beat_repeat_looper_unit import blr_pkg::*; #(
  parameter int unsigned LOOP_DEPTH = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  blr_in_if.sink     in_i,
  blr_out_if.source  out_o,
  blr_cfg_if.sink    cfg_i
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  blr_entry_t push_entry, pop_entry;

  blr_front #(
    .LOOP_DEPTH(LOOP_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .entry_o      (push_entry)
  );

  blr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  blr_back #(
    .LOOP_DEPTH(LOOP_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule

[sim/beat_repeat_looper_unit_tb.sv]
// Self-checking testbench for beat_repeat_looper_unit: records one loop, then mixes
// the repeat window under many register settings and random handshake pressure.
// Depends on blr_pkg, the blr_*_if interfaces and the beat_repeat_looper_unit RTL.
`timescale 1ns / 1ps

module beat_repeat_looper_unit_tb;
  import blr_pkg::*;

  localparam int unsigned LOOP_ENTRIES = 65536;
  localparam int unsigned RECORD_LEN = 400;
  localparam int unsigned SHRUNK_LEN = 200;
  localparam int unsigned RECORD_ITEMS = 250;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_CAP = 20;
  localparam int unsigned RUN_LIMIT_NS = 60_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;

  // Mirror of the looper: registers, capture state, loop memory and pending outputs
  class stutter_scoreboard;
    typedef struct packed {
      sample_t left;
      sample_t right;
    } frame_t;

    logic [LEN_W-1:0] loop_len;
    logic [CNT_W-1:0] rep_count;
    logic [SEL_W-1:0] sel_six;
    logic             en;
    bit               recording;
    bit               captured;
    int unsigned      write_pos;
    int unsigned      stored_count;
    sample_t          loop_mem [LOOP_ENTRIES];
    frame_t           mixed_frames[$];
    int unsigned      bad_frames;

    function new();
      loop_len = LEN_W'(LEN_RESET);
      rep_count = CNT_W'(COUNT_RESET);
      sel_six = SEL_W'(SEL_RESET);
      en = 1'b1;
      recording = 0;
      captured = 0;
      write_pos = 0;
      stored_count = 0;
      bad_frames = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOOP_LENGTH:  loop_len = data[LEN_W-1:0];
        REG_REPEAT_COUNT: rep_count = data[CNT_W-1:0];
        REG_SELECTED:     sel_six = data[SEL_W-1:0];
        REG_ENABLE:       en = data[0];
        default: ;
      endcase
    endfunction

    // Clamp the loop length register to the usable range
    function int unsigned eff_len();
      if (loop_len < LEN_MIN) return LEN_MIN;
      if (loop_len > LOOP_ENTRIES) return LOOP_ENTRIES;
      return 32'(loop_len);
    endfunction

    function void repeat_bounds(output int unsigned start, output int unsigned stop);
      int unsigned len;
      int unsigned six;
      len = eff_len();
      six = len / 16;
      start = ((sel_six + 1) * six) % len;
      stop = (start + six * rep_count) % len;
    endfunction

    function int unsigned pending();
      return mixed_frames.size();
    endfunction

    // Record, then mix the stored slice into the left channel inside the window and copy it to the right
    function void note_sample(sample_t left, sample_t right, logic [POS_W-1:0] pos,
                              logic [TICK_W-1:0] tick);
      int unsigned len;
      int unsigned six;
      int unsigned rel;
      int unsigned start;
      int unsigned stop;
      bit          in_win;
      int          sum;
      frame_t      f;
      len = eff_len();
      if (tick == 0 && !recording && !captured) recording = 1;
      if (recording) begin
        loop_mem[write_pos] = left;
        if (write_pos + 1 > stored_count) stored_count = write_pos + 1;
        if (write_pos + 1 >= len) begin
          recording = 0;
          captured = 1;
          write_pos = 0;
        end else begin
          write_pos++;
        end
      end
      f.left = left;
      f.right = right;
      if (captured && en) begin
        six = len / 16;
        rel = pos % len;
        repeat_bounds(start, stop);
        if (stop < start) in_win = (rel > start && rel < len) || (rel > 0 && rel < stop);
        else in_win = rel > start && rel < stop;
        if (in_win) begin
          sum = int'(left) + int'(loop_mem[rel % six]);
          if (sum > int'(SAT_MAX)) sum = int'(SAT_MAX);
          if (sum < int'(SAT_MIN)) sum = int'(SAT_MIN);
          f.left = sample_t'(sum);
          f.right = f.left;
        end
      end
      mixed_frames.push_back(f);
    endfunction

    function void match_output(sample_t out_l, sample_t out_r);
      frame_t f;
      if (mixed_frames.size() == 0) begin
        bad_frames++;
        if (bad_frames <= REPORT_CAP)
          $display("%0t: output with none pending: actual left %0d right %0d",
                   $time, out_l, out_r);
        return;
      end
      f = mixed_frames.pop_front();
      if (out_l !== f.left || out_r !== f.right) begin
        bad_frames++;
        if (bad_frames <= REPORT_CAP)
          $display("%0t: output mismatch: expected left %0d right %0d, actual left %0d right %0d",
                   $time, f.left, f.right, out_l, out_r);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned burst_left = 0;
  stutter_scoreboard sb = new();

  blr_in_if  in_ch ();
  blr_out_if out_ch ();
  blr_cfg_if cfg_ch ();

  beat_repeat_looper_unit #(.LOOP_DEPTH(LOOP_ENTRIES)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("[beat_repeat_looper_unit] ERROR");
    $finish;
  end

  // Take outputs, stalling on a randomly chosen pattern
  initial begin
    int unsigned stall_mode;
    int unsigned stall_run;
    logic [7:0]  ready_pattern;
    stall_mode = 0;
    stall_run = 0;
    ready_pattern = '1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready)
        sb.match_output(out_ch.out_left, out_ch.out_right);
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(40, 300);
        ready_pattern = 8'($urandom);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ready_pattern[stall_run % 8];
      endcase
    end
  end

  // Send one sample transaction, in bursts separated by random gaps
  task automatic send_sample(input sample_t left, input sample_t right,
                             input logic [POS_W-1:0] pos, input logic [TICK_W-1:0] tick);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_left <= left;
    in_ch.sample_right <= right;
    in_ch.loop_position <= pos;
    in_ch.sixteenth_tick <= tick;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_sample(left, right, pos, tick);
    burst_left--;
  endtask

  // Drop valid and hold until every pending output has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Leave valid high so back-to-back writes follow without a gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_register(idx, data);
  endtask

  task automatic cfg_done();
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return SAT_MAX - sample_t'($urandom_range(0, 15));
      3: return SAT_MIN + sample_t'($urandom_range(0, 15));
      4: return sample_t'($urandom_range(0, 3)) - sample_t'(2);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Pick a position, often near the window edges; keep slice reads inside the
  // recorded part of the loop memory
  function automatic logic [POS_W-1:0] pick_position(input int unsigned rel_hint,
                                                     input bit use_hint);
    int unsigned len;
    int unsigned six;
    int unsigned rel;
    int unsigned start;
    int unsigned stop;
    int unsigned span;
    len = sb.eff_len();
    six = len / 16;
    sb.repeat_bounds(start, stop);
    if (use_hint) begin
      rel = rel_hint % len;
    end else begin
      case ($urandom_range(0, 3))
        0: rel = (start + len + $urandom_range(0, 4) - 2) % len;
        1: rel = (stop + len + $urandom_range(0, 4) - 2) % len;
        default: rel = $urandom_range(0, len - 1);
      endcase
    end
    if (six > sb.stored_count) rel = rel - rel % six + (rel % six) % sb.stored_count;
    span = (65535 - rel) / len;
    if ($urandom_range(0, 1)) rel = rel + len * $urandom_range(0, span);
    return POS_W'(rel);
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] len_data;
    logic [CFG_DATA_W-1:0] cnt_data;
    logic [CFG_DATA_W-1:0] sel_data;
    logic [CFG_DATA_W-1:0] en_data;
    case ($urandom_range(0, 7))
      0: len_data = CFG_DATA_W'($urandom_range(0, 16));
      1: len_data = CFG_DATA_W'($urandom_range(65536, 131071));
      2: len_data = CFG_DATA_W'($urandom_range(4032, 65535));
      default: len_data = CFG_DATA_W'($urandom_range(17, 4031));
    endcase
    cnt_data = CFG_DATA_W'($urandom);
    cnt_data[CNT_W-1:0] = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 31))
                                                      : CNT_W'($urandom_range(1, 8));
    if ($urandom_range(0, 1)) cnt_data[CFG_DATA_W-1:CNT_W] = '0;
    sel_data = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1)) sel_data[CFG_DATA_W-1:SEL_W] = '0;
    en_data = CFG_DATA_W'($urandom);
    en_data[0] = ($urandom_range(0, 4) != 0);
    write_reg(REG_LOOP_LENGTH, len_data);
    write_reg(REG_REPEAT_COUNT, cnt_data);
    write_reg(REG_SELECTED, sel_data);
    write_reg(REG_ENABLE, en_data);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_done();
  endtask

  initial begin
    int unsigned seq_rel;
    bit          seq_mode;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample_left <= '0;
    in_ch.sample_right <= '0;
    in_ch.loop_position <= '0;
    in_ch.sixteenth_tick <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Keep the first recording short
    write_reg(REG_LOOP_LENGTH, CFG_DATA_W'(RECORD_LEN));
    cfg_done();

    // Off the bar start nothing is recorded and samples pass
    send_sample(SAT_MAX, SAT_MIN, 16'h0000, 4'd15);
    send_sample(SAT_MIN, SAT_MAX, 16'hFFFF, 4'd1);
    send_sample(0, -1, 16'h5555, 4'd8);
    send_sample(-1, 0, 16'hAAAA, 4'd4);

    // Bar start: record extremes into the first two slots, then random content
    send_sample(SAT_MAX, pick_sample(), POS_W'($urandom), 4'd0);
    send_sample(SAT_MIN, pick_sample(), POS_W'($urandom), TICK_W'($urandom));
    repeat (RECORD_ITEMS - 2)
      send_sample(pick_sample(), pick_sample(), POS_W'($urandom), TICK_W'($urandom));

    // Shrink the loop mid-recording: the next sample completes the capture and
    // already plays back (window 12..24, slot 1 holds the negative extreme)
    wait_drained();
    write_reg(REG_LOOP_LENGTH, CFG_DATA_W'(SHRUNK_LEN));
    cfg_done();
    send_sample(-5, 77, 16'd13, 4'd0);
    send_sample(SAT_MAX, SAT_MIN, 16'd12, 4'd3);
    send_sample(100, -100, 16'd23, 4'd7);
    send_sample(100, -100, 16'd24, 4'd8);
    send_sample(100, 5, 16'd213, 4'd9);
    send_sample(1, 2, 16'hFFFF, 4'd15);

    // Wrapping window 192..28
    wait_drained();
    write_reg(REG_REPEAT_COUNT, 3);
    write_reg(REG_SELECTED, 15);
    cfg_done();
    send_sample(SAT_MAX, 0, 16'd24, 4'd0);
    send_sample(3, 4, 16'd0, 4'd1);
    send_sample(3, 4, 16'd199, 4'd2);
    send_sample(3, 4, 16'd1, 4'd3);
    send_sample(3, 4, 16'd28, 4'd4);
    send_sample(3, 4, 16'd192, 4'd5);
    send_sample(3, 4, 16'd193, 4'd6);

    // Playback off; upper data bits must be ignored
    wait_drained();
    write_reg(REG_ENABLE, 17'h1FFFE);
    cfg_done();
    send_sample(3, 4, 16'd1, 4'd7);

    // Count of sixteen on a length that is not a multiple of sixteen
    wait_drained();
    write_reg(REG_ENABLE, 1);
    write_reg(REG_REPEAT_COUNT, 16);
    cfg_done();
    send_sample(3, 4, 16'd100, 4'd8);

    // Count above sixteen
    wait_drained();
    write_reg(REG_REPEAT_COUNT, 31);
    write_reg(REG_SELECTED, 0);
    cfg_done();
    send_sample(3, 4, 16'd150, 4'd9);

    // Length below the floor: empty window, then a window of two sixteenths
    wait_drained();
    write_reg(REG_LOOP_LENGTH, 5);
    write_reg(REG_REPEAT_COUNT, 16);
    cfg_done();
    send_sample(SAT_MIN, SAT_MAX, 16'd5, 4'd4);
    wait_drained();
    write_reg(REG_REPEAT_COUNT, 2);
    write_reg(REG_SELECTED, 3);
    cfg_done();
    send_sample(SAT_MIN, 9, 16'd21, 4'd5);
    send_sample(7, 8, 16'd6, 4'd6);

    // Length above the ceiling, with an ignored register index
    wait_drained();
    write_reg(REG_LOOP_LENGTH, 17'h1FFFF);
    write_reg(REG_SELECTED, 0);
    write_reg(REG_REPEAT_COUNT, 1);
    write_reg(REG_UNUSED, 17'h0ABCD);
    cfg_done();
    send_sample(10, 11, 16'd4097, 4'd10);
    send_sample(10, 11, 16'hFFFF, 4'd11);

    // Random settings, with either scattered or sweeping positions
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      random_config();
      seq_mode = 1'($urandom_range(0, 1));
      seq_rel = $urandom;
      repeat (PHASE_ITEMS) begin
        send_sample(pick_sample(), pick_sample(), pick_position(seq_rel, seq_mode),
                    TICK_W'($urandom));
        seq_rel++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.bad_frames == 0 && sb.pending() == 0) begin
      $display("[beat_repeat_looper_unit] OK");
    end else begin
      $display("[beat_repeat_looper_unit] ERROR");
    end
    $finish;
  end

endmodule
